>>> rtl/core/text_terminal_cursor_scroll_core_assert.svh
// assertion macros for the text terminal core
// used by the modules that carry concurrent checks; no other dependencies
`ifndef TEXT_TERMINAL_CURSOR_SCROLL_CORE_ASSERT_SVH
`define TEXT_TERMINAL_CURSOR_SCROLL_CORE_ASSERT_SVH

// same-cycle implication
`define TTCS_ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// next-cycle implication
`define TTCS_ASSERT_NXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

>>> rtl/core/ttcs_pkg.sv
// shared types, codes and constants of the text terminal core
// no dependencies
`default_nettype none

package ttcs_pkg;

  localparam int DEF_COLUMNS = 80;
  localparam int DEF_ROWS    = 25;

  localparam int OP_W        = 2;
  localparam int CHAR_W      = 8;
  localparam int COLOR_W     = 4;
  localparam int ROW_FIELD_W = 5;
  localparam int COL_FIELD_W = 7;

  localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
  localparam logic [OP_W-1:0] OP_READ  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  localparam logic [CHAR_W-1:0]  NEWLINE_CHAR = 8'd10;
  localparam logic [CHAR_W-1:0]  SPACE_CHAR   = 8'd32;
  localparam logic [COLOR_W-1:0] COLOR_CYAN   = 4'd3;

  typedef struct packed {
    logic [OP_W-1:0]        operation;
    logic [CHAR_W-1:0]      character;
    logic [COLOR_W-1:0]     color;
    logic [ROW_FIELD_W-1:0] read_row;
    logic [COL_FIELD_W-1:0] read_column;
  } in_item_t;

  typedef struct packed {
    logic [CHAR_W-1:0]      cell_character;
    logic [COLOR_W-1:0]     cell_color;
    logic [ROW_FIELD_W-1:0] cursor_row;
    logic [COL_FIELD_W-1:0] cursor_column;
    logic                   scrolled;
  } out_item_t;

  typedef struct packed {
    logic [COLOR_W-1:0] color;
    logic [CHAR_W-1:0]  character;
  } cell_t;

  localparam cell_t BLANK_CELL = '{color: COLOR_CYAN, character: SPACE_CHAR};

  typedef struct packed {
    logic load;
    logic exec;
    logic wr_cur;
    logic fill_start;
    logic scroll_start;
    logic clear_start;
    logic sweep_wr;
    logic rd_en;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] operation;
    logic            newline;
    logic            wrap_scroll;
    logic            scroll_pending;
    logic            sweep_done;
  } dp_sts_t;

endpackage

`default_nettype wire

>>> rtl/core/ttcs_ctrl.sv
// control state machine of the text terminal core
// depends on ttcs_pkg and the assertion macro header
`default_nettype none
`include "text_terminal_cursor_scroll_core_assert.svh"

module ttcs_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output ttcs_pkg::dp_cmd_t      cmd,
  input  wire ttcs_pkg::dp_sts_t sts
);
  import ttcs_pkg::*;

  typedef enum logic [5:0] {
    S_INIT  = 6'b000001,
    S_IDLE  = 6'b000010,
    S_EXEC  = 6'b000100,
    S_FILL  = 6'b001000,
    S_SWEEP = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_INIT: begin
        cmd.sweep_wr = 1'b1;
        if (sts.sweep_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        case (sts.operation)
          OP_PUT: begin
            if (sts.newline) begin
              cmd.fill_start = 1'b1;
              state_nxt      = S_FILL;
            end else begin
              cmd.wr_cur = 1'b1;
              if (sts.wrap_scroll) begin
                cmd.scroll_start = 1'b1;
                state_nxt        = S_SWEEP;
              end else if (slot_free) begin
                cmd.out_load = 1'b1;
                state_nxt    = S_IDLE;
              end else begin
                state_nxt = S_DONE;
              end
            end
          end
          OP_READ: begin
            cmd.rd_en = 1'b1;
            state_nxt = S_DONE;
          end
          OP_CLEAR: begin
            cmd.clear_start = 1'b1;
            state_nxt       = S_SWEEP;
          end
          default: begin
            if (slot_free) begin
              cmd.out_load = 1'b1;
              state_nxt    = S_IDLE;
            end else begin
              state_nxt = S_DONE;
            end
          end
        endcase
      end
      S_FILL: begin
        cmd.sweep_wr = 1'b1;
        if (sts.sweep_done) begin
          if (sts.scroll_pending) begin
            cmd.scroll_start = 1'b1;
            state_nxt        = S_SWEEP;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_SWEEP: begin
        cmd.sweep_wr = 1'b1;
        if (sts.sweep_done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `TTCS_ASSERT_NXT(a_accept_exec, clk, rst_n, in_valid && in_ready, state_r == S_EXEC)
  `TTCS_ASSERT_IMP(a_no_overwrite, clk, rst_n, cmd.out_load, !out_valid_r || out_ready)
  `TTCS_ASSERT_NXT(a_sweep_hold, clk, rst_n, (state_r == S_SWEEP) && !sts.sweep_done,
                   state_r == S_SWEEP)

endmodule

`default_nettype wire

>>> rtl/core/ttcs_datapath.sv
// screen memory, cursor, scroll offset and sweep counter of the text terminal core
// depends on ttcs_pkg
`default_nettype none

module ttcs_datapath #(
  parameter int COLS = ttcs_pkg::DEF_COLUMNS,
  parameter int ROWS = ttcs_pkg::DEF_ROWS
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire ttcs_pkg::in_item_t in_data,
  output ttcs_pkg::out_item_t     out_data,
  input  wire ttcs_pkg::dp_cmd_t  cmd,
  output ttcs_pkg::dp_sts_t       sts
);
  import ttcs_pkg::*;

  localparam int CELLS = ROWS * COLS;
  localparam int AW    = $clog2(CELLS);
  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLS);
  localparam logic [RW:0]   ROWS_EXT = (RW+1)'(ROWS);
  localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);
  localparam logic [CW-1:0] LAST_COL = CW'(COLS - 1);

  in_item_t  item_r;
  out_item_t out_r, out_nxt;
  logic [RW-1:0] cur_row_r, cur_row_nxt, top_r, top_nxt;
  logic [CW-1:0] cur_col_r, cur_col_nxt;
  logic          scroll_r, scroll_nxt;
  logic [AW-1:0] sw_addr_r, sw_addr_nxt, sw_end_r, sw_end_nxt;
  cell_t         sw_cell_r, sw_cell_nxt;

  cell_t         mem [CELLS];
  cell_t         rd_data_r;
  logic          rd_ok_r;

  logic          newline, last_row, wrap, sweep_done, rd_ok;
  logic [AW-1:0] cur_addr, cur_base, top_base, rd_addr, mem_waddr;
  logic          mem_we;
  cell_t         mem_wdata;

  function automatic logic [AW-1:0] cell_addr(logic [RW-1:0] row, logic [CW-1:0] col,
                                              logic [RW-1:0] top);
    logic [RW:0]   sum;
    logic [RW-1:0] phys;
    sum = {1'b0, row} + {1'b0, top};
    if (sum >= ROWS_EXT) begin
      sum = sum - ROWS_EXT;
    end
    phys = sum[RW-1:0];
    return AW'(phys) * AW'(COLS) + AW'(col);
  endfunction

  assign newline    = (item_r.character == NEWLINE_CHAR);
  assign last_row   = (cur_row_r == LAST_ROW);
  assign wrap       = newline || (cur_col_r == LAST_COL);
  assign sweep_done = (sw_addr_r == sw_end_r);
  assign cur_addr   = cell_addr(cur_row_r, cur_col_r, top_r);
  assign cur_base   = cell_addr(cur_row_r, '0, top_r);
  assign top_base   = AW'(top_r) * AW'(COLS);
  assign rd_addr    = cell_addr(RW'(item_r.read_row), CW'(item_r.read_column), top_r);
  assign rd_ok      = (32'(item_r.read_row) < 32'(ROWS)) &&
                      (32'(item_r.read_column) < 32'(COLS));

  assign sts.operation      = item_r.operation;
  assign sts.newline        = newline;
  assign sts.wrap_scroll    = wrap && last_row;
  assign sts.scroll_pending = scroll_r;
  assign sts.sweep_done     = sweep_done;

  always_comb begin
    cur_row_nxt = cur_row_r;
    cur_col_nxt = cur_col_r;
    top_nxt     = top_r;
    scroll_nxt  = scroll_r;
    sw_addr_nxt = sw_addr_r;
    sw_end_nxt  = sw_end_r;
    sw_cell_nxt = sw_cell_r;
    if (cmd.exec) begin
      scroll_nxt = (item_r.operation == OP_PUT) && wrap && last_row;
      if (item_r.operation == OP_PUT) begin
        if (wrap) begin
          cur_col_nxt = '0;
          if (!last_row) begin
            cur_row_nxt = cur_row_r + RW'(1);
          end
        end else begin
          cur_col_nxt = cur_col_r + CW'(1);
        end
      end
    end
    if (cmd.sweep_wr && !sweep_done) begin
      sw_addr_nxt = sw_addr_r + AW'(1);
    end
    if (cmd.fill_start) begin
      sw_addr_nxt = cur_addr;
      sw_end_nxt  = cur_base + AW'(COLS - 1);
      sw_cell_nxt = '{color: item_r.color, character: SPACE_CHAR};
    end
    if (cmd.scroll_start) begin
      sw_addr_nxt = top_base;
      sw_end_nxt  = top_base + AW'(COLS - 1);
      sw_cell_nxt = BLANK_CELL;
      top_nxt     = (top_r == LAST_ROW) ? '0 : top_r + RW'(1);
    end
    if (cmd.clear_start) begin
      cur_row_nxt = '0;
      cur_col_nxt = '0;
      top_nxt     = '0;
      sw_addr_nxt = '0;
      sw_end_nxt  = AW'(CELLS - 1);
      sw_cell_nxt = BLANK_CELL;
    end
  end

  assign mem_we    = cmd.wr_cur || cmd.sweep_wr;
  assign mem_waddr = cmd.wr_cur ? cur_addr : sw_addr_r;
  assign mem_wdata = cmd.wr_cur ? cell_t'{color: item_r.color, character: item_r.character}
                                : sw_cell_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[rd_addr];
      rd_ok_r   <= rd_ok;
    end
  end

  always_comb begin
    out_nxt.cell_character = '0;
    out_nxt.cell_color     = '0;
    if ((item_r.operation == OP_READ) && rd_ok_r) begin
      out_nxt.cell_character = rd_data_r.character;
      out_nxt.cell_color     = rd_data_r.color;
    end
    out_nxt.cursor_row    = ROW_FIELD_W'(cur_row_nxt);
    out_nxt.cursor_column = COL_FIELD_W'(cur_col_nxt);
    out_nxt.scrolled      = scroll_nxt;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_data;
    end
    if (cmd.out_load) begin
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_row_r <= '0;
      cur_col_r <= '0;
      top_r     <= '0;
      scroll_r  <= 1'b0;
      sw_addr_r <= '0;
      sw_end_r  <= AW'(CELLS - 1);
      sw_cell_r <= BLANK_CELL;
    end else begin
      cur_row_r <= cur_row_nxt;
      cur_col_r <= cur_col_nxt;
      top_r     <= top_nxt;
      scroll_r  <= scroll_nxt;
      sw_addr_r <= sw_addr_nxt;
      sw_end_r  <= sw_end_nxt;
      sw_cell_r <= sw_cell_nxt;
    end
  end

  assign out_data = out_r;

endmodule

`default_nettype wire

>>> rtl/core/text_terminal_cursor_scroll_core.sv
// the result register loads after the accepting edge, once the operation is done: a read waits for the memory read,
// a newline put first blanks the row from the cursor to its end, a clear blanks the whole screen,
// and a scroll blanks one row of SCREEN_COLUMNS cells
// one transaction at a time: the next input is taken only after the result is loaded
// reset starts a clearing pass over all SCREEN_ROWS*SCREEN_COLUMNS cells (2000 by default)
// before the first input transaction is taken; cursor and scroll offset reset to zero
`default_nettype none

module text_terminal_cursor_scroll_core #(
  parameter int SCREEN_COLUMNS = ttcs_pkg::DEF_COLUMNS,
  parameter int SCREEN_ROWS    = ttcs_pkg::DEF_ROWS
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire ttcs_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output ttcs_pkg::out_item_t      out_data
);
  import ttcs_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  ttcs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  ttcs_datapath #(
    .COLS (SCREEN_COLUMNS),
    .ROWS (SCREEN_ROWS)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .out_data (out_data),
    .cmd      (cmd),
    .sts      (sts)
  );

endmodule

`default_nettype wire
